>>> sv/ptest_pkg.sv
// shared types and constants for the primality tester
package ptest_pkg;
  localparam int NUM_W = 32;
  localparam int PROD_W = 62;
  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [NUM_W-1:0] BASE_A = 32'd2;
  localparam logic [NUM_W-1:0] BASE_B = 32'd7;
  localparam logic [NUM_W-1:0] BASE_C = 32'd61;

  // front-end decision for one item
  typedef enum logic [1:0] {
    CLS_NOT_PRIME = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TEST      = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [NUM_W-1:0] n;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_BASE,
    ST_MUL,
    ST_RED,
    ST_NEXT,
    ST_FIRST,
    ST_STRONG
  } eng_state_t;

  // what the running modular multiply is for
  typedef enum logic [1:0] {
    MK_POW_SQ,
    MK_POW_MUL,
    MK_CHK_SQ
  } mul_kind_t;
endpackage

>>> sv/ptest_front.sv
// front end: takes items, classifies them and queues jobs for the engine
module ptest_front #(
  parameter int DEPTH = ptest_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [ptest_pkg::NUM_W-1:0] in_number,
  output logic                        job_valid,
  output ptest_pkg::job_t             job,
  input  logic                        job_take
);
  import ptest_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  job_t            cls_job;
  logic            do_push, do_pop;

  always_comb begin
    cls_job.n = in_number;
    if (in_number[NUM_W-1] || in_number <= 32'd1) begin
      cls_job.cls = CLS_NOT_PRIME;
    end else if (in_number == BASE_A) begin
      cls_job.cls = CLS_PRIME;
    end else begin
      cls_job.cls = CLS_TEST;
    end
  end

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign job_valid = (cnt_r != '0);
  assign job       = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= cls_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

>>> sv/ptest_engine.sv
// back end: miller-rabin engine with a bit-serial modular reducer
module ptest_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  input  ptest_pkg::job_t             job,
  output logic                        job_take,
  output logic                        res_valid,
  output logic                        res_bit,
  input  logic                        res_take
);
  import ptest_pkg::*;

  eng_state_t        st_r, st_nxt;
  mul_kind_t         kind_r;
  logic [NUM_W-1:0]  n_r, d_r, a_r, x_r;
  logic [4:0]        s_r, k_r, ebit_r, rcnt_r;
  logic [PROD_W-1:0] rem_r;
  logic              resv_r, resb_r;
  logic [PROD_W-1:0] sub_m, red_nxt;
  logic [NUM_W-2:0]  mul_b;
  logic [NUM_W-1:0]  nm1, a_next;
  logic              more_base, more_k, chk_hit;
  logic              res_set, res_val, base_pass;

  assign nm1     = n_r - 1'b1;
  assign more_k  = (k_r < s_r);
  assign chk_hit = (x_r == nm1);
  // restoring reduction: compare against n shifted by the step count
  assign sub_m   = PROD_W'(n_r) << rcnt_r;
  assign red_nxt = (rem_r >= sub_m) ? rem_r - sub_m : rem_r;
  // operands are below n, so they fit in 31 bits
  assign mul_b   = (kind_r == MK_POW_MUL) ? a_r[NUM_W-2:0] : x_r[NUM_W-2:0];

  // next base, if it applies to this n
  always_comb begin
    more_base = 1'b0;
    a_next    = a_r;
    if (a_r == BASE_A && n_r > BASE_B) begin
      more_base = 1'b1;
      a_next    = BASE_B;
    end else if (a_r == BASE_B && n_r > BASE_C) begin
      more_base = 1'b1;
      a_next    = BASE_C;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    job_take  = 1'b0;
    res_set   = 1'b0;
    res_val   = 1'b0;
    base_pass = 1'b0;
    unique case (st_r)
      ST_IDLE: if (job_valid && !resv_r) begin
        job_take = 1'b1;
        if (job.cls == CLS_TEST) begin
          st_nxt = ST_SPLIT;
        end else begin
          res_set = 1'b1;
          res_val = (job.cls == CLS_PRIME);
        end
      end
      ST_SPLIT: if (d_r[0] || s_r == 5'd31) st_nxt = ST_BASE;
      ST_BASE:  st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_RED;
      ST_RED:   if (rcnt_r == '0) st_nxt = ST_NEXT;
      ST_NEXT: begin
        unique case (kind_r)
          MK_POW_SQ: begin
            if (d_r[ebit_r]) st_nxt = ST_MUL;
            else if (ebit_r == '0) st_nxt = ST_FIRST;
            else st_nxt = ST_MUL;
          end
          MK_POW_MUL: st_nxt = (ebit_r == '0) ? ST_FIRST : ST_MUL;
          MK_CHK_SQ:  st_nxt = ST_STRONG;
          default:    st_nxt = ST_IDLE;
        endcase
      end
      ST_FIRST: begin
        if (x_r == 32'd1) base_pass = 1'b1;
        else st_nxt = ST_STRONG;
      end
      ST_STRONG: begin
        if (chk_hit) begin
          base_pass = 1'b1;
        end else if (more_k) begin
          st_nxt = ST_MUL;
        end else begin
          res_set = 1'b1;
          res_val = 1'b0;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (base_pass) begin
      if (more_base) begin
        st_nxt = ST_BASE;
      end else begin
        res_set = 1'b1;
        res_val = 1'b1;
        st_nxt  = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // finished verdict waits here until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resv_r <= 1'b0;
    end else if (res_set) begin
      resv_r <= 1'b1;
    end else if (res_take && resv_r) begin
      resv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) resb_r <= res_val;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (job_take) begin
        n_r <= job.n;
        d_r <= job.n - 1'b1;
        s_r <= '0;
        a_r <= BASE_A;
      end
      // strip trailing zeros of n-1, one per cycle
      ST_SPLIT: if (!d_r[0] && s_r != 5'd31) begin
        d_r <= d_r >> 1;
        s_r <= s_r + 1'b1;
      end
      ST_BASE: begin
        x_r    <= 32'd1;
        ebit_r <= 5'd31;
        kind_r <= MK_POW_SQ;
      end
      ST_MUL: begin
        rem_r  <= PROD_W'(x_r[NUM_W-2:0]) * PROD_W'(mul_b);
        rcnt_r <= 5'd31;
      end
      ST_RED: begin
        rem_r <= red_nxt;
        if (rcnt_r == '0) x_r <= NUM_W'(red_nxt);
        else rcnt_r <= rcnt_r - 1'b1;
      end
      ST_NEXT: begin
        unique case (kind_r)
          MK_POW_SQ: begin
            if (d_r[ebit_r]) kind_r <= MK_POW_MUL;
            else if (ebit_r != '0) ebit_r <= ebit_r - 1'b1;
          end
          MK_POW_MUL: if (ebit_r != '0) begin
            ebit_r <= ebit_r - 1'b1;
            kind_r <= MK_POW_SQ;
          end
          default: ;
        endcase
      end
      ST_FIRST: k_r <= 5'd1;
      ST_STRONG: if (!chk_hit && more_k) begin
        k_r    <= k_r + 1'b1;
        kind_r <= MK_CHK_SQ;
      end
      default: ;
    endcase
    if (base_pass && more_base) a_r <= a_next;
  end

  assign res_valid = resv_r;
  assign res_bit   = resb_r;
endmodule

>>> sv/primality_test_32bit.sv
// top level: deterministic miller-rabin primality tester, bases 2, 7 and 61
// numbers of 1 or below and 2 are decided without any modular multiply
// per base: 32 squarings, one multiply per set bit of d, then up to s-1 squarings;
//   each modular multiply is a 31x31 multiply plus a 32-step reduction
// throughput: one item at a time; the engine takes the next once the result is popped
// reset: synchronous active-low rst_n empties the queue and idles the engine
module primality_test_32bit #(
  parameter int FIFO_DEPTH = ptest_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [ptest_pkg::NUM_W-1:0] in_number,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_is_prime
);
  import ptest_pkg::*;

  // job queue between front end and engine
  logic job_valid, job_take, res_valid;
  job_t job;

  ptest_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst_n, .push, .full, .in_number,
    .job_valid, .job, .job_take
  );

  // engine holds one finished result until popped
  ptest_engine u_engine (
    .clk, .rst_n, .job_valid, .job, .job_take,
    .res_valid, .res_bit(out_is_prime), .res_take(pop)
  );

  assign empty = !res_valid;

  // the engine is idle while a result waits, so a pop always empties the output
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty |=> empty) else $error("pop did not clear");
  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_is_prime)) else $error("result changed");
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> job_valid) else $error("full with empty queue");
endmodule

>>> tb/primality_test_32bit_chk.sv
// checker for the primality tester: predicts each verdict and compares it
`timescale 1ns / 1ps
module primality_test_32bit_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        full,
  input  logic [ptest_pkg::NUM_W-1:0] in_number,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        out_is_prime,
  output int                          fail_count,
  output int                          pending,
  output int                          verdicts_seen,
  output int                          primes_seen
);
  import ptest_pkg::*;

  logic verdict_q[$];
  logic [NUM_W-1:0] number_q[$];

  function automatic logic [NUM_W-1:0] mod_mul(logic [NUM_W-1:0] x, logic [NUM_W-1:0] y,
                                               logic [NUM_W-1:0] m);
    logic [63:0] p;
    p = {32'd0, x} * {32'd0, y};
    return NUM_W'(p % {32'd0, m});
  endfunction

  function automatic logic [NUM_W-1:0] mod_pow(logic [NUM_W-1:0] b, logic [NUM_W-1:0] e,
                                               logic [NUM_W-1:0] m);
    logic [NUM_W-1:0] acc;
    acc = 1;
    for (int i = NUM_W - 1; i >= 0; i--) begin
      acc = mod_mul(acc, acc, m);
      if (e[i]) acc = mod_mul(acc, b, m);
    end
    return acc;
  endfunction

  function automatic bit strong_witness_ok(logic [NUM_W-1:0] a, logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] d, x;
    int s;
    d = n - 1;
    s = 0;
    while (!d[0] && s < 31) begin
      d = d >> 1;
      s++;
    end
    x = mod_pow(a, d, n);
    if (x == 1) return 1;
    for (int k = 1; k < s; k++) begin
      if (x == n - 1) return 1;
      x = mod_mul(x, x, n);
    end
    return x == n - 1;
  endfunction

  function automatic logic predict_prime(logic [NUM_W-1:0] n);
    if (n[NUM_W-1] || n <= 1) return 0;
    if (n == 2) return 1;
    if (!strong_witness_ok(BASE_A, n)) return 0;
    if (n > BASE_B && !strong_witness_ok(BASE_B, n)) return 0;
    if (n > BASE_C && !strong_witness_ok(BASE_C, n)) return 0;
    return 1;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    verdicts_seen = 0;
    primes_seen = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        verdict_q.push_back(predict_prime(in_number));
        number_q.push_back(in_number);
      end
      if (pop && !empty) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("is_prime: verdict %0b with no item outstanding", out_is_prime);
          fail_count++;
        end else begin
          logic e;
          logic [NUM_W-1:0] n;
          e = verdict_q.pop_front();
          n = number_q.pop_front();
          if (e) primes_seen++;
          if (out_is_prime !== e) begin
            $error("is_prime for %0d: expected %0b actual %0b", $signed(n), e, out_is_prime);
            fail_count++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end
endmodule

>>> tb/primality_test_32bit_tb.sv
// testbench top: drives numbers into the primality tester and gives the verdict
`timescale 1ns / 1ps
module primality_test_32bit_tb;
  import ptest_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic pop = 0;
  logic [NUM_W-1:0] in_number = '0;
  logic full, empty, out_is_prime;
  int fail_count, pending, verdicts_seen, primes_seen;
  int send_idle_pct, recv_idle_pct;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  primality_test_32bit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_number(in_number),
    .empty(empty), .pop(pop), .out_is_prime(out_is_prime)
  );

  primality_test_32bit_chk chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_number(in_number),
    .empty(empty), .pop(pop), .out_is_prime(out_is_prime),
    .fail_count(fail_count), .pending(pending),
    .verdicts_seen(verdicts_seen), .primes_seen(primes_seen)
  );

  // receiver: random pop stalls at the falling edge
  always @(negedge clk) begin
    if (rst_n) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // sends one item; push stays high across back-to-back items
  task automatic send_number(logic [NUM_W-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    in_number <= n;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // random number: mostly odd positives, some numbers near a known prime, some noise
  function automatic logic [NUM_W-1:0] pick_number();
    int k;
    k = $urandom_range(9);
    unique case (k)
      0: return $urandom();
      1: return $urandom_range(200);
      2: return 32'h7FFF_FFFF - $urandom_range(300);
      3: return {1'b1, 31'($urandom())};
      default: return {1'b0, 30'($urandom()), 1'b1};
    endcase
  endfunction

  localparam logic [NUM_W-1:0] DIRECTED [0:22] = '{
    32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
    32'd7, 32'd9, 32'd11, 32'd25, 32'd61, 32'd67, 32'd2047, 32'd3215031751,
    32'd464155845, 32'd2147483647, 32'd2147483646,
    32'd2147483629, 32'd1000000007, 32'd561, 32'h5555_5555
  };

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, trivial cases, small primes, strong pseudoprimes, then random numbers
    send_idle_pct = 19;
    recv_idle_pct = 60;
    foreach (DIRECTED[i]) send_number(DIRECTED[i]);
    for (int i = 0; i < 26; i++) send_number(pick_number());

    // swap the stall rates of the two sides
    send_idle_pct = 60;
    recv_idle_pct = 19;
    for (int i = 0; i < 26; i++) send_number(pick_number());

    // no stalls on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 26; i++) send_number(pick_number());
    push <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("run covered %0d verdicts, %0d of them prime, under three stall patterns",
             verdicts_seen, primes_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // about 100 items, with stalls, and a wide margin
  initial begin
    #20_000_000;
    $display("timeout with %0d verdicts outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> files.f
sv/ptest_pkg.sv
sv/ptest_front.sv
sv/ptest_engine.sv
sv/primality_test_32bit.sv
tb/primality_test_32bit_chk.sv
tb/primality_test_32bit_tb.sv
